FILE: rtl/afg_pkg.sv
package afg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 31;
    localparam int PROD_W   = 2 * LEN_W;
    localparam int GAIN_W   = 15;
    localparam int FRAC_SH  = 14;
    localparam int RATE_SH  = 16;
    localparam int RATE_W   = 30;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int S_TDATA_W = 48;

    localparam int DIV_DIVIDEND_W = PROD_W;
    localparam int DIV_DIVISOR_W  = LEN_W + 1;
    localparam int DIV_CNT_W      = $clog2(DIV_DIVIDEND_W);

    localparam logic [RATE_W:0] ONE30 = {1'b1, {RATE_W{1'b0}}};

    localparam logic [1:0] REG_FADE_IN  = 2'd0;
    localparam logic [1:0] REG_FADE_OUT = 2'd1;
    localparam logic [1:0] REG_CLIP     = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_MUTE,
        MODE_RAMP
    } afg_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UP,
        ST_DOWN,
        ST_SPLIT
    } afg_state_t;

    typedef struct packed {
        logic [LEN_W-1:0] fade_in_len;
        logic [LEN_W-1:0] fade_out_len;
        logic [LEN_W-1:0] clip_len;
        logic [LEN_W-1:0] step_up;
        logic [LEN_W-1:0] step_down;
        logic [LEN_W-1:0] fade_in_end;
        logic [LEN_W-1:0] fade_out_start;
        logic             ready;
    } afg_derived_t;

endpackage

FILE: rtl/afg_div.sv
module afg_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [afg_pkg::DIV_DIVIDEND_W-1:0]     dividend,
    input  logic [afg_pkg::DIV_DIVISOR_W-1:0]      divisor,
    output logic                                   done,
    output logic [afg_pkg::DIV_DIVIDEND_W-1:0]     quotient
);

    logic [afg_pkg::DIV_DIVIDEND_W-1:0] quo_reg;
    logic [afg_pkg::DIV_DIVISOR_W-1:0]  rem_reg;
    logic [afg_pkg::DIV_DIVISOR_W-1:0]  div_reg;
    logic [afg_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic [afg_pkg::DIV_DIVISOR_W:0]    trial;
    logic [afg_pkg::DIV_DIVISOR_W:0]    trial_sub;
    logic                               qbit;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[afg_pkg::DIV_DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, div_reg};
        qbit      = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= afg_pkg::DIV_CNT_W'(afg_pkg::DIV_DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[afg_pkg::DIV_DIVIDEND_W-2:0], qbit};
            rem_reg <= qbit ? trial_sub[afg_pkg::DIV_DIVISOR_W-1:0]
                            : trial[afg_pkg::DIV_DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/afg_derive.sv
module afg_derive (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afg_pkg::ADDR_W-1:0]   paddr,
    input  logic [afg_pkg::DATA_W-1:0]   pwdata,
    output logic [afg_pkg::DATA_W-1:0]   prdata,
    output afg_pkg::afg_derived_t        derived
);

    localparam int LW = afg_pkg::LEN_W;

    afg_pkg::afg_state_t state_reg;
    afg_pkg::afg_state_t state_next;

    logic [LW-1:0] fade_in_len_reg;
    logic [LW-1:0] fade_out_len_reg;
    logic [LW-1:0] clip_len_reg;
    logic [LW-1:0] step_up_reg;
    logic [LW-1:0] step_down_reg;
    logic [LW-1:0] fade_in_end_reg;
    logic [LW-1:0] fade_out_start_reg;
    logic [afg_pkg::PROD_W-1:0] split_prod_reg;

    logic                                  cfg_wr;
    logic [1:0]                            reg_idx;
    logic                                  div_start;
    logic [afg_pkg::DIV_DIVIDEND_W-1:0]    div_dividend;
    logic [afg_pkg::DIV_DIVISOR_W-1:0]     div_divisor;
    logic                                  div_done;
    logic [afg_pkg::DIV_DIVIDEND_W-1:0]    div_quotient;
    logic [LW:0]                           len_sum;
    logic                                  do_split;
    logic [LW-1:0]                         tail_start;

    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        case (reg_idx)
            afg_pkg::REG_FADE_IN:  prdata = {1'b0, fade_in_len_reg};
            afg_pkg::REG_FADE_OUT: prdata = {1'b0, fade_out_len_reg};
            afg_pkg::REG_CLIP:     prdata = {1'b0, clip_len_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_in_len_reg  <= '0;
            fade_out_len_reg <= '0;
            clip_len_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                afg_pkg::REG_FADE_IN:  fade_in_len_reg  <= pwdata[LW-1:0];
                afg_pkg::REG_FADE_OUT: fade_out_len_reg <= pwdata[LW-1:0];
                afg_pkg::REG_CLIP:     clip_len_reg     <= pwdata[LW-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        len_sum    = {1'b0, fade_in_len_reg} + {1'b0, fade_out_len_reg};
        do_split   = ({1'b0, clip_len_reg} < len_sum) && (fade_in_len_reg != '0)
                     && (fade_out_len_reg != '0);
        tail_start = (clip_len_reg > fade_out_len_reg) ? (clip_len_reg - fade_out_len_reg)
                                                       : '0;
    end

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = afg_pkg::DIV_DIVIDEND_W'(afg_pkg::ONE30);
        div_divisor  = {1'b0, fade_in_len_reg};
        case (state_reg)
            afg_pkg::ST_IDLE:
            begin
            end
            afg_pkg::ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = afg_pkg::ST_UP;
            end
            afg_pkg::ST_UP:
            begin
                div_divisor = {1'b0, fade_out_len_reg};
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = afg_pkg::ST_DOWN;
                end
            end
            afg_pkg::ST_DOWN:
            begin
                div_dividend = split_prod_reg;
                div_divisor  = len_sum;
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = afg_pkg::ST_SPLIT;
                end
            end
            afg_pkg::ST_SPLIT:
            begin
                if (div_done)
                begin
                    state_next = afg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = afg_pkg::ST_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            div_start  = 1'b0;
            state_next = afg_pkg::ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == afg_pkg::ST_LOAD)
        begin
            split_prod_reg <= clip_len_reg * fade_in_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_up_reg        <= '0;
            step_down_reg      <= '0;
            fade_in_end_reg    <= '0;
            fade_out_start_reg <= '0;
        end
        else if (div_done && !cfg_wr)
        begin
            case (state_reg)
                afg_pkg::ST_UP:
                begin
                    step_up_reg <= (fade_in_len_reg != '0) ? div_quotient[LW-1:0] : '0;
                end
                afg_pkg::ST_DOWN:
                begin
                    step_down_reg <= (fade_out_len_reg != '0) ? div_quotient[LW-1:0] : '0;
                end
                afg_pkg::ST_SPLIT:
                begin
                    fade_in_end_reg    <= do_split ? div_quotient[LW-1:0] : fade_in_len_reg;
                    fade_out_start_reg <= do_split ? div_quotient[LW-1:0] : tail_start;
                end
                default: ;
            endcase
        end
    end

    afg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        derived.fade_in_len    = fade_in_len_reg;
        derived.fade_out_len   = fade_out_len_reg;
        derived.clip_len       = clip_len_reg;
        derived.step_up        = step_up_reg;
        derived.step_down      = step_down_reg;
        derived.fade_in_end    = fade_in_end_reg;
        derived.fade_out_start = fade_out_start_reg;
        derived.ready          = (state_reg == afg_pkg::ST_IDLE);
    end

endmodule

FILE: rtl/afg_gain_pipe.sv
module afg_gain_pipe (
    input  logic                             clk,
    input  logic                             rst_n,
    input  afg_pkg::afg_derived_t            derived,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [afg_pkg::SAMPLE_W-1:0]     pcm_in,
    input  logic [afg_pkg::LEN_W-1:0]        position,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [afg_pkg::SAMPLE_W-1:0]     pcm_out
);

    localparam int LW = afg_pkg::LEN_W;
    localparam int SW = afg_pkg::SAMPLE_W;
    localparam int PW = afg_pkg::PROD_W;
    localparam int GW = afg_pkg::GAIN_W;
    localparam int RW = afg_pkg::RATE_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;
    logic in_fire;

    afg_pkg::afg_mode_t mode1_reg, mode2_reg, mode3_reg, mode4_reg;
    logic               fadeout1_reg, fadeout2_reg;
    logic [SW-1:0]      sample1_reg, sample2_reg, sample3_reg, sample4_reg;
    logic [LW-1:0]      mul_a1_reg, mul_b1_reg;
    logic [PW-1:0]      prod2_reg;
    logic [GW-1:0]      gain3_reg;
    logic signed [2*SW-1:0] sprod4_reg;
    logic [SW-1:0]      out5_reg;

    afg_pkg::afg_mode_t mode_c;
    logic               fadeout_c;
    logic [LW-1:0]      mul_a_c, mul_b_c;
    logic [LW:0]        into_c;
    logic [RW:0]        rate_c;
    logic [GW-1:0]      gain_c;
    logic signed [2*SW-1:0] shifted_c;
    logic [SW-1:0]      out_c;

    assign adv5     = !v5_reg || m_tready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = derived.ready && adv1;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        into_c    = {1'b0, position} + {1'b0, derived.fade_out_len}
                    - {1'b0, derived.clip_len};
        mode_c    = afg_pkg::MODE_PASS;
        fadeout_c = 1'b0;
        mul_a_c   = derived.step_up;
        mul_b_c   = position;
        if ((derived.fade_in_len == '0) && (derived.fade_out_len == '0))
        begin
            mode_c = afg_pkg::MODE_PASS;
        end
        else if (position >= derived.clip_len)
        begin
            mode_c = afg_pkg::MODE_MUTE;
        end
        else if (position < derived.fade_in_end)
        begin
            mode_c = afg_pkg::MODE_RAMP;
        end
        else if (position >= derived.fade_out_start)
        begin
            mode_c    = afg_pkg::MODE_RAMP;
            fadeout_c = 1'b1;
            mul_a_c   = derived.step_down;
            mul_b_c   = into_c[LW-1:0];
        end
    end

    always_comb
    begin
        rate_c = afg_pkg::ONE30 - {1'b0, prod2_reg[RW-1:0]};
        if (!fadeout2_reg)
        begin
            gain_c = prod2_reg[afg_pkg::RATE_SH+GW-1:afg_pkg::RATE_SH];
        end
        else if (prod2_reg[PW-1:RW] == '0)
        begin
            gain_c = rate_c[afg_pkg::RATE_SH+GW-1:afg_pkg::RATE_SH];
        end
        else
        begin
            gain_c = '0;
        end
    end

    always_comb
    begin
        shifted_c = sprod4_reg >>> afg_pkg::FRAC_SH;
        case (mode4_reg)
            afg_pkg::MODE_PASS: out_c = sample4_reg;
            afg_pkg::MODE_MUTE: out_c = '0;
            afg_pkg::MODE_RAMP: out_c = shifted_c[SW-1:0];
            default:            out_c = sample4_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_fire;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode1_reg    <= mode_c;
            fadeout1_reg <= fadeout_c;
            sample1_reg  <= pcm_in;
            mul_a1_reg   <= mul_a_c;
            mul_b1_reg   <= mul_b_c;
        end
        if (adv2 && v1_reg)
        begin
            mode2_reg    <= mode1_reg;
            fadeout2_reg <= fadeout1_reg;
            sample2_reg  <= sample1_reg;
            prod2_reg    <= mul_a1_reg * mul_b1_reg;
        end
        if (adv3 && v2_reg)
        begin
            mode3_reg   <= mode2_reg;
            sample3_reg <= sample2_reg;
            gain3_reg   <= gain_c;
        end
        if (adv4 && v3_reg)
        begin
            mode4_reg   <= mode3_reg;
            sample4_reg <= sample3_reg;
            sprod4_reg  <= $signed(sample3_reg) * $signed({1'b0, gain3_reg});
        end
        if (adv5 && v4_reg)
        begin
            out5_reg <= out_c;
        end
    end

    assign m_tvalid = v5_reg;
    assign pcm_out  = out5_reg;

endmodule

FILE: rtl/audio_fade_in_out_gain_core.sv
// Linear fade-in and fade-out gain for a stream of 16-bit audio samples.
// The slave stream carries one sample per transfer together with its frame
// position from the clip start; the master stream returns one faded sample
// for every accepted transfer, in order.
// Three registers on the APB port set the fade-in, fade-out and clip lengths.
// After any register write the block recomputes its ramp steps and the fade
// boundaries with one shared bit-serial divider, three divisions of 62 steps
// each plus setup, while s_tready stays low. Registers are to be written
// only while no sample is in flight; the block does not enforce this.
// Samples flow through a five-stage pipeline: region decode, ramp multiply,
// gain extraction, sample multiply and output shift. One sample per cycle
// is sustained while the receiver is ready and no recompute runs.
// When the receiver stalls, the stages fill up and s_tready falls only once
// every stage holds a sample; nothing is dropped or repeated.
// Reset clears the registers and the pipeline; with all lengths zero the
// block passes samples unchanged and accepts data right away.
module audio_fade_in_out_gain_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Bits from the lowest: pcm_in[15:0], position[46:16], zero pad.
    input  logic [afg_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Bits from the lowest: pcm_out[15:0].
    output logic [afg_pkg::SAMPLE_W-1:0]      m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afg_pkg::ADDR_W-1:0]        paddr,
    input  logic [afg_pkg::DATA_W-1:0]        pwdata,
    output logic [afg_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    afg_pkg::afg_derived_t derived;

    assign pready = 1'b1;

    afg_derive u_derive (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .derived (derived)
    );

    afg_gain_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .derived  (derived),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pcm_in   (s_tdata[afg_pkg::SAMPLE_W-1:0]),
        .position (s_tdata[afg_pkg::SAMPLE_W+afg_pkg::LEN_W-1:afg_pkg::SAMPLE_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .pcm_out  (m_tdata)
    );

endmodule

FILE: rtl/afg_checker.sv
module afg_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [afg_pkg::SAMPLE_W-1:0]      m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready
);

    // A register write starts a recompute, so no transfer is taken right after it.
    a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> !s_tready)
        else $error("s_tready high right after a register write");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result withdrawn");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind audio_fade_in_out_gain_core afg_checker u_afg_checker (.*);

FILE: tb/audio_fade_in_out_gain_core_tb.sv
`timescale 1ns / 1ps

module audio_fade_in_out_gain_core_tb;

    localparam int          LEN_W       = afg_pkg::LEN_W;
    localparam int          SAMPLE_W    = afg_pkg::SAMPLE_W;
    localparam int          DATA_W      = afg_pkg::DATA_W;
    localparam int          ADDR_W      = afg_pkg::ADDR_W;
    localparam int          S_TDATA_W   = afg_pkg::S_TDATA_W;
    localparam int          RATE_SH     = afg_pkg::RATE_SH;
    localparam int          FRAC_SH     = afg_pkg::FRAC_SH;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          DRAIN_WAIT  = 20;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam logic [30:0] LEN_MAX     = 31'h7FFF_FFFF;
    localparam logic [63:0] UNITY_RATE  = 64'h4000_0000;

    class fade_gain_tracker;
        logic [LEN_W-1:0]    fade_in_len;
        logic [LEN_W-1:0]    fade_out_len;
        logic [LEN_W-1:0]    clip_len;
        logic [LEN_W-1:0]    step_up;
        logic [LEN_W-1:0]    step_down;
        logic [LEN_W-1:0]    fade_in_end;
        logic [LEN_W-1:0]    fade_out_start;
        logic [SAMPLE_W-1:0] expected_samples[$];
        int                  mismatches;

        function new();
            fade_in_len  = '0;
            fade_out_len = '0;
            clip_len     = '0;
            mismatches   = 0;
            derive_bounds();
        endfunction

        function void derive_bounds();
            logic [63:0] lin;
            logic [63:0] lout;
            logic [63:0] ln;
            logic [63:0] split;
            lin  = 64'(fade_in_len);
            lout = 64'(fade_out_len);
            ln   = 64'(clip_len);
            step_up   = (lin != 0) ? LEN_W'(UNITY_RATE / lin) : '0;
            step_down = (lout != 0) ? LEN_W'(UNITY_RATE / lout) : '0;
            if (ln < lin + lout && lin != 0 && lout != 0)
            begin
                split          = (ln * lin) / (lin + lout);
                fade_in_end    = LEN_W'(split);
                fade_out_start = LEN_W'(split);
            end
            else
            begin
                fade_in_end    = fade_in_len;
                fade_out_start = (ln > lout) ? LEN_W'(ln - lout) : '0;
            end
        endfunction

        function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                afg_pkg::REG_FADE_IN:  fade_in_len  = value[LEN_W-1:0];
                afg_pkg::REG_FADE_OUT: fade_out_len = value[LEN_W-1:0];
                afg_pkg::REG_CLIP:     clip_len     = value[LEN_W-1:0];
                default:               return;
            endcase
            derive_bounds();
        endfunction

        function logic [SAMPLE_W-1:0] faded_sample(logic [SAMPLE_W-1:0] sample,
                                                   logic [LEN_W-1:0] pos);
            logic [63:0] rate;
            logic [63:0] into;
            logic [63:0] dec;
            int          gain;
            int          prod;
            if (fade_in_len == 0 && fade_out_len == 0)
                return sample;
            if (pos >= clip_len)
                return '0;
            if (pos < fade_in_end)
            begin
                rate = 64'(step_up) * 64'(pos);
            end
            else if (pos >= fade_out_start)
            begin
                into = 64'(pos) + 64'(fade_out_len) - 64'(clip_len);
                dec  = 64'(step_down) * into;
                rate = (dec < UNITY_RATE) ? UNITY_RATE - dec : 64'd0;
            end
            else
            begin
                return sample;
            end
            gain = int'(rate >> RATE_SH);
            prod = int'($signed(sample)) * gain;
            return SAMPLE_W'(prod >>> FRAC_SH);
        endfunction

        function void note_input(logic [SAMPLE_W-1:0] sample, logic [LEN_W-1:0] pos);
            expected_samples.push_back(faded_sample(sample, pos));
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output sample %0d", $signed(actual));
                return;
            end
            want = expected_samples.pop_front();
            if (actual !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output sample mismatch: expected %0d, got %0d",
                             $signed(want), $signed(actual));
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    fade_gain_tracker tracker;
    int               cycles          = 0;
    int               send_gap_odds   = 0;
    int               recv_stall_odds = 0;
    int               stall_left      = 0;

    audio_fade_in_out_gain_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (recv_stall_odds > 0 && $urandom_range(1, recv_stall_odds) == 1)
        begin
            stall_left <= $urandom_range(0, 9);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                               input logic [LEN_W-1:0] pos);
        @(negedge clk);
        if (send_gap_odds > 0 && $urandom_range(1, send_gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, sample};
        do @(posedge clk); while (!s_tready);
        tracker.note_input(sample, pos);
    endtask

    task automatic drain_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [LEN_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = {1'($urandom_range(0, 1)), value};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_fades(input logic [LEN_W-1:0] in_len, input logic [LEN_W-1:0] out_len,
                             input logic [LEN_W-1:0] clip);
        drain_stream();
        write_register(afg_pkg::REG_FADE_IN, in_len);
        write_register(afg_pkg::REG_FADE_OUT, out_len);
        write_register(afg_pkg::REG_CLIP, clip);
    endtask

    // Most positions fall between zero and span; some span the whole field.
    task automatic send_random(input int count, input logic [LEN_W-1:0] span);
        logic [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]    pos;
        repeat (count)
        begin
            case ($urandom_range(0, 15))
                0:       sample = 16'h8000;
                1:       sample = 16'h7FFF;
                default: sample = SAMPLE_W'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0)
                pos = LEN_W'($urandom);
            else
                pos = LEN_W'($urandom_range(0, 32'(span)));
            send_sample(sample, pos);
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] rin;
        logic [LEN_W-1:0] rout;
        logic [LEN_W-1:0] rclip;
        tracker = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gap_odds   = 4;
        recv_stall_odds = 4;
        send_sample(16'h8000, 31'd0);
        send_sample(16'h7FFF, LEN_MAX);
        send_sample(16'h0000, 31'd5);
        send_sample(16'hFFFF, 31'd12345);
        send_random(30, 31'd1000);

        set_fades(31'd16, 31'd16, 31'd100);
        send_sample(16'h7FFF, 31'd0);
        send_sample(16'h8000, 31'd1);
        send_sample(16'h7FFF, 31'd15);
        send_sample(16'h8000, 31'd16);
        send_sample(16'd12345, 31'd50);
        send_sample(16'h7FFF, 31'd83);
        send_sample(16'h8000, 31'd84);
        send_sample(16'h7FFF, 31'd99);
        send_sample(16'h8000, 31'd100);
        send_sample(16'h0001, LEN_MAX);
        send_random(20, 31'd120);
        drain_stream();
        send_random(20, 31'd120);

        drain_stream();
        write_register(REG_UNUSED, LEN_W'($urandom));
        set_fades(31'd80, 31'd60, 31'd100);
        send_sample(16'h7FFF, 31'd56);
        send_sample(16'h8000, 31'd57);
        send_sample(16'h7FFF, 31'd99);
        send_sample(16'hFFFF, 31'd0);
        send_random(40, 31'd120);

        send_gap_odds   = 2;
        recv_stall_odds = 8;
        set_fades(31'd200, 31'd0, 31'd100);
        send_sample(16'h7FFF, 31'd99);
        send_sample(16'h8000, 31'd100);
        send_random(35, 31'd120);

        set_fades(31'd0, 31'd30, 31'd50);
        send_random(35, 31'd60);

        send_gap_odds   = 8;
        recv_stall_odds = 2;
        set_fades(31'd1, 31'd1, 31'd1);
        send_random(25, 31'd4);

        send_gap_odds   = 0;
        recv_stall_odds = 0;
        set_fades(LEN_MAX, LEN_MAX, LEN_MAX);
        send_random(35, LEN_MAX);

        send_gap_odds   = 3;
        recv_stall_odds = 3;
        set_fades(LEN_MAX, 31'd0, LEN_MAX);
        send_random(30, LEN_MAX);

        set_fades(31'd0, 31'd1, 31'd0);
        send_random(20, 31'd4);

        repeat (2)
        begin
            rin   = LEN_W'($urandom_range(0, 300));
            rout  = LEN_W'($urandom_range(0, 300));
            rclip = LEN_W'($urandom_range(0, 600));
            set_fades(rin, rout, rclip);
            send_random(40, rclip + rclip / 4 + 31'd4);
        end

        send_gap_odds   = 0;
        recv_stall_odds = 0;
        set_fades(31'd1000, 31'd2000, 31'd10000);
        send_random(50, 31'd12000);

        drain_stream();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_samples.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
